// ----- rtl/core/lmk_pkg.sv -----
// Shared types, codes and helper functions for the landmark map block.
`default_nettype none

package lmk_pkg;

    // Command codes of an input transaction.
    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Status codes of a result transaction.
    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_ADDED   = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_VALID   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BASE_NOISE   = 2'd0;
    localparam logic [1:0] REG_RANGE_FACTOR = 2'd1;
    localparam logic [1:0] REG_ASSOC_RADIUS = 2'd2;
    localparam logic [1:0] REG_VALIDATE     = 2'd3;

    // Register reset values.
    localparam logic [31:0] RST_BASE_NOISE   = 32'd3277;
    localparam logic [15:0] RST_RANGE_FACTOR = 16'd655;
    localparam logic [31:0] RST_ASSOC_RADIUS = 32'd65536;
    localparam logic [19:0] RST_VALIDATE     = 20'd196608;

    // Confidence floor (0.1 in Q0.16), trust cap (15.0 in Q4.16), unit gain in Q1.31.
    localparam logic [15:0] CONF_FLOOR = 16'd6554;
    localparam logic [19:0] TRUST_CAP  = 20'd983040;
    localparam logic [31:0] K_ONE      = 32'h8000_0000;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic               command;
        logic signed [31:0] det_x;
        logic signed [31:0] det_y;
        logic [15:0]        det_conf;
        logic [1:0]         det_side;
        logic signed [31:0] car_x;
        logic signed [31:0] car_y;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        cone_id;
        logic signed [31:0] cone_x;
        logic signed [31:0] cone_y;
        logic [31:0]        cone_variance;
        logic [1:0]         cone_side;
        logic [19:0]        cone_trust;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [31:0] base_noise;
        logic [15:0] range_factor_sq;
        logic [31:0] assoc_radius_sq;
        logic [19:0] validate_level;
    } cfg_t;

    // Classified work passed from front to back.
    typedef struct packed {
        logic               command;
        logic signed [31:0] det_x;
        logic signed [31:0] det_y;
        logic [15:0]        det_conf;
        logic [1:0]         det_side;
        logic [31:0]        mvar;
    } job_t;

    // One landmark table row.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        variance;
        logic [1:0]         side;
        logic [19:0]        trust;
        logic [31:0]        ident;
        logic               validated;
    } entry_t;

    // Magnitude of the difference of two signed 32-bit values; it always fits 32 bits.
    function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [32:0] n;
        d = 33'(a) - 33'(b);
        n = -d;
        return d[32] ? n[31:0] : d[31:0];
    endfunction

    // Sum of two squares, saturating at the full 64-bit range.
    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/landmark_map_nn_kalman_update_top.sv -----
// Top level of the landmark map: configuration registers, front, queue and back.
// Front: a detect goes through multiplies and, when the noise is below the squared
// confidence, a variance division. Back: a detect runs a nearest-entry search over every
// stored entry, then the gain division and blend on a match; a read checks every stored
// entry and then ends the readout.
// Reset clears the entry count, the id counter and the registers; no clearing pass.
`default_nettype none

module landmark_map_nn_kalman_update_top
    import lmk_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             result_valid,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t cfg_reg;
    logic push, full, pop, empty;
    job_t push_data, head;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_noise      <= RST_BASE_NOISE;
            cfg_reg.range_factor_sq <= RST_RANGE_FACTOR;
            cfg_reg.assoc_radius_sq <= RST_ASSOC_RADIUS;
            cfg_reg.validate_level  <= RST_VALIDATE;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_BASE_NOISE:   cfg_reg.base_noise      <= pwdata;
                REG_RANGE_FACTOR: cfg_reg.range_factor_sq <= pwdata[15:0];
                REG_ASSOC_RADIUS: cfg_reg.assoc_radius_sq <= pwdata;
                REG_VALIDATE:     cfg_reg.validate_level  <= pwdata[19:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (reg_idx)
            REG_BASE_NOISE:   prdata = cfg_reg.base_noise;
            REG_RANGE_FACTOR: prdata = 32'(cfg_reg.range_factor_sq);
            REG_ASSOC_RADIUS: prdata = cfg_reg.assoc_radius_sq;
            REG_VALIDATE:     prdata = 32'(cfg_reg.validate_level);
            default:          prdata = '0;
        endcase
    end

    lmk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    lmk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    lmk_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (empty),
        .pop          (pop),
        .head         (head),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lmk_div.sv -----
// Restoring divider producing a fractional quotient one bit per cycle.
`default_nettype none

module lmk_div
    import lmk_pkg::*;
#(
    parameter int W  = 32,
    parameter int QW = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire logic [W-1:0]  num,
    input  wire logic [W-1:0]  den,
    output logic               done,
    output logic [QW-1:0]      quo
);

    localparam int CW = $clog2(QW + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [W:0] rem2;
    logic       ge;
    logic [W:0] rem_step;

    // One quotient bit per cycle; the remainder stays below the divisor.
    always_comb
    begin
        rem2     = {rem_reg, 1'b0};
        ge       = rem2 >= {1'b0, den_reg};
        rem_step = ge ? rem2 - {1'b0, den_reg} : rem2;
    end

    // Control: step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                cnt_reg <= CW'(QW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_step[W-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lmk_front.sv -----
// Front end: accepts commands and computes the measurement variance of detections.
`default_nettype none

module lmk_front
    import lmk_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output logic       push,
    output job_t       push_data,
    input  wire logic  full
);

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_MAG  = 4'd1;
    localparam logic [3:0] F_SQX  = 4'd2;
    localparam logic [3:0] F_SQY  = 4'd3;
    localparam logic [3:0] F_RNG  = 4'd4;
    localparam logic [3:0] F_MUL  = 4'd5;
    localparam logic [3:0] F_CHK  = 4'd6;
    localparam logic [3:0] F_DIV  = 4'd7;
    localparam logic [3:0] F_PUSH = 4'd8;

    logic [3:0]  state_reg, state_next;
    item_t       item_reg;
    logic [31:0] magx_reg, magy_reg;
    logic [31:0] csq_reg;
    logic [63:0] sqx_reg, sqy_reg;
    logic [47:0] r_reg;
    logic [48:0] noise_reg;
    logic [31:0] mvar_reg;

    logic        accept;
    logic [15:0] conf_sc;
    logic [63:0] dsum;
    logic [63:0] rprod;
    logic        div_go;
    logic        div_done;
    logic [31:0] div_quo;

    assign accept = start && (state_reg == F_IDLE);
    assign busy   = (state_reg != F_IDLE);

    // Clamp the confidence, sum the squared range, scale it and decide on the division.
    always_comb
    begin
        conf_sc = (item_reg.det_conf < CONF_FLOOR) ? CONF_FLOOR : item_reg.det_conf;
        dsum    = sat_sum(sqx_reg, sqy_reg);
        rprod   = 64'(r_reg) * 64'(cfg.range_factor_sq);
        div_go  = (state_reg == F_CHK) && (noise_reg < 49'(csq_reg));
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
                if (accept)
                    state_next = (item.command == CMD_READ) ? F_PUSH : F_MAG;
            F_MAG:  state_next = F_SQX;
            F_SQX:  state_next = F_SQY;
            F_SQY:  state_next = F_RNG;
            F_RNG:  state_next = F_MUL;
            F_MUL:  state_next = F_CHK;
            F_CHK:  state_next = div_go ? F_DIV : F_PUSH;
            F_DIV:
                if (div_done)
                    state_next = F_PUSH;
            F_PUSH:
                if (!full)
                    state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers, at most one multiplication per step.
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        case (state_reg)
            F_MAG:
            begin
                magx_reg <= abs_diff(item_reg.det_x, item_reg.car_x);
                magy_reg <= abs_diff(item_reg.det_y, item_reg.car_y);
                csq_reg  <= 32'(conf_sc) * 32'(conf_sc);
            end
            F_SQX: sqx_reg <= 64'(magx_reg) * 64'(magx_reg);
            F_SQY: sqy_reg <= 64'(magy_reg) * 64'(magy_reg);
            F_RNG: r_reg   <= dsum[63:16];
            F_MUL: noise_reg <= 49'(cfg.base_noise) + 49'(rprod[63:16]);
            F_CHK:
                if (!div_go)
                    mvar_reg <= {32{1'b1}};
            F_DIV:
                if (div_done)
                    mvar_reg <= div_quo;
            default:
            begin
            end
        endcase
    end

    // Noise is below the squared confidence here, so the quotient fits 32 bits.
    lmk_div #(.W(32), .QW(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (noise_reg[31:0]),
        .den   (csq_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Hand the classified transaction to the queue.
    always_comb
    begin
        push                = (state_reg == F_PUSH) && !full;
        push_data.command   = item_reg.command;
        push_data.det_x     = item_reg.det_x;
        push_data.det_y     = item_reg.det_y;
        push_data.det_conf  = item_reg.det_conf;
        push_data.det_side  = item_reg.det_side;
        push_data.mvar      = mvar_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/lmk_queue.sv -----
// Short queue of classified transactions between front and back.
`default_nettype none

module lmk_queue
    import lmk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output job_t      head
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    job_t          slots [Q_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slots[rp_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PW'(Q_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == PW'(Q_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wp_reg] <= push_data;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/lmk_back.sv -----
// Back end: nearest-entry search, Kalman blend, table append or drop and validated readout.
`default_nettype none

module lmk_back
    import lmk_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic empty,
    output logic      pop,
    input  wire job_t head,
    output logic      result_valid,
    output result_t   result
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [4:0] B_IDLE   = 5'd0;
    localparam logic [4:0] D_ADDR   = 5'd1;
    localparam logic [4:0] D_MAG    = 5'd2;
    localparam logic [4:0] D_SQX    = 5'd3;
    localparam logic [4:0] D_SQY    = 5'd4;
    localparam logic [4:0] D_CMP    = 5'd5;
    localparam logic [4:0] D_DECIDE = 5'd6;
    localparam logic [4:0] K_ADDR   = 5'd7;
    localparam logic [4:0] K_LOAD   = 5'd8;
    localparam logic [4:0] K_DIV    = 5'd9;
    localparam logic [4:0] K_MULX   = 5'd10;
    localparam logic [4:0] K_MULY   = 5'd11;
    localparam logic [4:0] K_MULP   = 5'd12;
    localparam logic [4:0] K_WB     = 5'd13;
    localparam logic [4:0] R_ADDR   = 5'd14;
    localparam logic [4:0] R_CHK    = 5'd15;
    localparam logic [4:0] R_END    = 5'd16;

    // Landmark table, one write and one registered read per cycle.
    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    // Control state.
    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      ident_reg, ident_next;
    logic             res_valid_reg, res_valid_next;
    logic             pend_valid_reg, pend_valid_next;

    // Working registers.
    job_t             job_reg, job_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] bi_reg, bi_next;
    logic             found_reg, found_next;
    logic [63:0]      best_reg, best_next;
    logic [31:0]      magx_reg, magx_next, magy_reg, magy_next;
    logic             negx_reg, negx_next, negy_reg, negy_next;
    logic [63:0]      sqx_reg, sqx_next, sqy_reg, sqy_next;
    entry_t           ent_reg, ent_next;
    logic [31:0]      k_reg, k_next;
    logic [32:0]      stepx_reg, stepx_next, stepy_reg, stepy_next;
    logic [32:0]      pstep_reg, pstep_next;
    entry_t           pend_reg, pend_next;
    result_t          res_reg, res_next;

    // Table write port.
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // Gain divider.
    logic        div_go;
    logic [32:0] div_num, div_den;
    logic        div_done;
    logic [30:0] div_quo;

    // Local helpers.
    logic [63:0] sq_sum;
    logic [63:0] mprod;
    logic [32:0] gsum;
    logic [32:0] nx, ny;
    logic [20:0] tsum;
    entry_t      upd;

    function automatic result_t from_entry(input logic [2:0] st, input entry_t e,
                                           input logic lst);
        result_t r;
        r.status        = st;
        r.cone_id       = e.ident;
        r.cone_x        = e.x;
        r.cone_y        = e.y;
        r.cone_variance = e.variance;
        r.cone_side     = e.side;
        r.cone_trust    = e.trust;
        r.last          = lst;
        return r;
    endfunction

    lmk_div #(.W(33), .QW(31)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Next-state and datapath logic.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ident_next      = ident_reg;
        res_valid_next  = 1'b0;
        pend_valid_next = pend_valid_reg;
        job_next        = job_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        bi_next         = bi_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        magx_next       = magx_reg;
        magy_next       = magy_reg;
        negx_next       = negx_reg;
        negy_next       = negy_reg;
        sqx_next        = sqx_reg;
        sqy_next        = sqy_reg;
        ent_next        = ent_reg;
        k_next          = k_reg;
        stepx_next      = stepx_reg;
        stepy_next      = stepy_reg;
        pstep_next      = pstep_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        pop             = 1'b0;
        we              = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;
        div_go          = 1'b0;
        gsum            = {1'b0, rd_data_reg.variance} + {1'b0, job_reg.mvar};
        div_num         = {1'b0, rd_data_reg.variance};
        div_den         = gsum;
        sq_sum          = sat_sum(sqx_reg, sqy_reg);
        mprod           = '0;
        nx              = negx_reg ? {ent_reg.x[31], ent_reg.x} - stepx_reg
                                   : {ent_reg.x[31], ent_reg.x} + stepx_reg;
        ny              = negy_reg ? {ent_reg.y[31], ent_reg.y} - stepy_reg
                                   : {ent_reg.y[31], ent_reg.y} + stepy_reg;
        tsum            = {1'b0, ent_reg.trust} + 21'(job_reg.det_conf);
        upd             = ent_reg;
        upd.x           = nx[31:0];
        upd.y           = ny[31:0];
        upd.variance    = ent_reg.variance - pstep_reg[31:0];
        upd.trust       = (tsum > 21'(TRUST_CAP)) ? TRUST_CAP : tsum[19:0];

        case (state_reg)
            // Take the next transaction from the queue.
            B_IDLE:
                if (!empty)
                begin
                    pop             = 1'b1;
                    job_next        = head;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    best_next       = {16'd0, cfg.assoc_radius_sq, 16'd0};
                    if (head.command == CMD_READ)
                        state_next = (count_reg == '0) ? R_END : R_ADDR;
                    else
                        state_next = (count_reg == '0) ? D_DECIDE : D_ADDR;
                end

            // Search: magnitude, two squares and a compare for each stored entry.
            D_ADDR: state_next = D_MAG;
            D_MAG:
            begin
                magx_next  = abs_diff(rd_data_reg.x, job_reg.det_x);
                magy_next  = abs_diff(rd_data_reg.y, job_reg.det_y);
                cur_next   = idx_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = D_SQX;
            end
            D_SQX:
            begin
                sqx_next   = 64'(magx_reg) * 64'(magx_reg);
                state_next = D_SQY;
            end
            D_SQY:
            begin
                sqy_next   = 64'(magy_reg) * 64'(magy_reg);
                state_next = D_CMP;
            end
            D_CMP:
            begin
                // Strict compare keeps the lowest index on a tie.
                if (sq_sum < best_reg)
                begin
                    best_next  = sq_sum;
                    bi_next    = cur_reg;
                    found_next = 1'b1;
                end
                state_next = (idx_reg == count_reg) ? D_DECIDE : D_MAG;
            end

            // Update the match, append, or drop when the table is full.
            D_DECIDE:
                if (found_reg)
                begin
                    idx_next   = bi_reg;
                    state_next = K_ADDR;
                end
                else if (count_reg == CNT_W'(MAX_ENTRIES))
                begin
                    res_next.status        = ST_DROPPED;
                    res_next.cone_id       = '0;
                    res_next.cone_x        = job_reg.det_x;
                    res_next.cone_y        = job_reg.det_y;
                    res_next.cone_variance = job_reg.mvar;
                    res_next.cone_side     = job_reg.det_side;
                    res_next.cone_trust    = 20'(job_reg.det_conf);
                    res_next.last          = 1'b1;
                    res_valid_next         = 1'b1;
                    state_next             = B_IDLE;
                end
                else
                begin
                    we                = 1'b1;
                    wr_addr           = count_reg[IDX_W-1:0];
                    wr_data.x         = job_reg.det_x;
                    wr_data.y         = job_reg.det_y;
                    wr_data.variance  = job_reg.mvar;
                    wr_data.side      = job_reg.det_side;
                    wr_data.trust     = 20'(job_reg.det_conf);
                    wr_data.ident     = ident_reg;
                    wr_data.validated = 1'b0;
                    res_next          = from_entry(ST_ADDED, wr_data, 1'b1);
                    res_valid_next    = 1'b1;
                    count_next        = count_reg + 1'b1;
                    ident_next        = ident_reg + 32'd1;
                    state_next        = B_IDLE;
                end

            // Kalman gain K = P * 2^31 / (P + R).
            K_ADDR: state_next = K_LOAD;
            K_LOAD:
            begin
                ent_next  = rd_data_reg;
                magx_next = abs_diff(job_reg.det_x, rd_data_reg.x);
                magy_next = abs_diff(job_reg.det_y, rd_data_reg.y);
                negx_next = job_reg.det_x < rd_data_reg.x;
                negy_next = job_reg.det_y < rd_data_reg.y;
                if (gsum == '0)
                begin
                    k_next     = '0;
                    state_next = K_MULX;
                end
                else if (job_reg.mvar == '0)
                begin
                    k_next     = K_ONE;
                    state_next = K_MULX;
                end
                else
                begin
                    div_go     = 1'b1;
                    state_next = K_DIV;
                end
            end
            K_DIV:
                if (div_done)
                begin
                    k_next     = {1'b0, div_quo};
                    state_next = K_MULX;
                end
            K_MULX:
            begin
                mprod      = 64'(magx_reg) * 64'(k_reg);
                stepx_next = mprod[63:31];
                state_next = K_MULY;
            end
            K_MULY:
            begin
                mprod      = 64'(magy_reg) * 64'(k_reg);
                stepy_next = mprod[63:31];
                state_next = K_MULP;
            end
            K_MULP:
            begin
                mprod      = 64'(ent_reg.variance) * 64'(k_reg);
                pstep_next = mprod[63:31];
                state_next = K_WB;
            end
            K_WB:
            begin
                we             = 1'b1;
                wr_addr        = bi_reg[IDX_W-1:0];
                wr_data        = upd;
                res_next       = from_entry(ST_UPDATED, upd, 1'b1);
                res_valid_next = 1'b1;
                state_next     = B_IDLE;
            end

            // Readout: hold one validated entry back so the final one carries last.
            R_ADDR: state_next = R_CHK;
            R_CHK:
            begin
                if (rd_data_reg.trust >= cfg.validate_level)
                begin
                    we                = 1'b1;
                    wr_data.validated = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next       = from_entry(ST_VALID, pend_reg, 1'b0);
                        res_valid_next = 1'b1;
                    end
                    pend_next       = rd_data_reg;
                    pend_valid_next = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == count_reg) ? R_END : R_ADDR;
            end
            R_END:
            begin
                if (pend_valid_reg)
                    res_next = from_entry(ST_VALID, pend_reg, 1'b1);
                else
                begin
                    res_next        = '0;
                    res_next.status = ST_NONE;
                    res_next.last   = 1'b1;
                end
                res_valid_next = 1'b1;
                state_next     = B_IDLE;
            end

            default: state_next = B_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            ident_reg      <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ident_reg      <= ident_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        bi_reg    <= bi_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        magx_reg  <= magx_next;
        magy_reg  <= magy_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        ent_reg   <= ent_next;
        k_reg     <= k_next;
        stepx_reg <= stepx_next;
        stepy_reg <= stepy_next;
        pstep_reg <= pstep_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
    end

    // Table memory.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_count_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> res_valid_reg && res_reg.status == ST_ADDED)
        else $error("entry count moved without an added result");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status == ST_DROPPED
            |-> count_reg == CNT_W'(MAX_ENTRIES) && res_reg.cone_id == '0)
        else $error("drop reported while table has room");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status == ST_NONE |-> res_reg.last && !pend_valid_reg)
        else $error("empty readout not final");

endmodule

`default_nettype wire
